FILE: rtl/mws_pkg.sv
// Package for the multi waveform shaper: widths, Q30 constants, shape codes,
// sequencer states and the coefficient tables of the shared multiplier.
// No dependencies.
package mws_pkg;

    localparam int PHASE_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int OUT_SHIFT   = 30 - FRAC_BITS;
    localparam int V_W         = 34;   // working width of a shape value (Q30)
    localparam int M_W         = 32;   // multiplier operand width

    localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h80200003;

    localparam logic signed [M_W-1:0] Q30_ONE   = 32'sd1073741824;
    localparam logic signed [M_W-1:0] RECT_DC   = 32'sd683565520;
    localparam logic signed [M_W-1:0] RECT_GAIN = 32'sd1686633657;
    localparam logic signed [M_W-1:0] SIN_C9    = 32'sd172272;

    localparam logic [2:0] SQ_LAST_K  = 3'd3;
    localparam logic [2:0] SAW_LAST_K = 3'd4;

    localparam logic [2:0] STEP_SQR  = 3'd0;
    localparam logic [2:0] STEP_C9   = 3'd1;
    localparam logic [2:0] STEP_C1   = 3'd4;
    localparam logic [2:0] STEP_SIN  = 3'd5;
    localparam logic [2:0] STEP_POST = 3'd6;

    typedef enum logic [3:0] {
        WAVE_SINE      = 4'd0,
        WAVE_SAW       = 4'd1,
        WAVE_INV_SAW   = 4'd2,
        WAVE_SQUARE    = 4'd3,
        WAVE_TRIANGLE  = 4'd4,
        WAVE_PULSE25   = 4'd5,
        WAVE_PULSE12   = 4'd6,
        WAVE_NOISE     = 4'd7,
        WAVE_BL_SQUARE = 4'd8,
        WAVE_BL_SAW    = 4'd9,
        WAVE_RECT_SINE = 4'd10,
        WAVE_TRAPEZOID = 4'd11,
        WAVE_STEP_SAW  = 4'd12
    } t_wave;

    localparam logic [3:0] WAVE_LAST = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_SETUP,
        ST_MUL,
        ST_POST,
        ST_FINAL
    } t_state;

    // Horner coefficient added after the product of the given step
    function automatic logic signed [M_W-1:0] sin_coef(input logic [2:0] step);
        logic signed [M_W-1:0] c;
        unique case (step)
            3'd1:    c = -32'sd5026995;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = -32'sd693598668;
            3'd4:    c = 32'sd1686629713;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [M_W-1:0] bl_weight(input logic is_square,
                                                        input logic [2:0] k);
        logic signed [M_W-1:0] w;
        if (is_square) begin
            unique case (k)
                3'd0:    w = 32'sd1148903752;
                3'd1:    w = 32'sd382967917;
                3'd2:    w = 32'sd229780750;
                3'd3:    w = 32'sd164129107;
                default: w = '0;
            endcase
        end else begin
            unique case (k)
                3'd0:    w = 32'sd676457349;
                3'd1:    w = 32'sd338228675;
                3'd2:    w = 32'sd225485783;
                3'd3:    w = 32'sd169114337;
                3'd4:    w = 32'sd135291470;
                default: w = '0;
            endcase
        end
        return w;
    endfunction

endpackage

FILE: rtl/multi_waveform_shaper_unit.sv
// Multi waveform shaper top level: phase word in, Q1.15 sample out.
// Uses mws_pkg for widths, shape codes, states and coefficient tables.
//
// Usage:
//   Write the shape index on i_cfg_data with i_cfg_we while idle; codes
//   above the stepped saw are ignored and the previous shape stays.
//   A word is taken on a clock edge with start high and busy low. The result
//   appears on o_sample / o_clipped for one cycle, marked by o_valid; the
//   receiver cannot stall, so it must take it in that cycle.
//   busy stays high while one word is worked on, and a new word is taken
//   only once busy is low again. Direct shapes (saw, inverted saw, square,
//   triangle, pulses, noise, trapezoid, stepped saw) are worked out without
//   the multiplier; the sine, rectified sine, band-limited square (4
//   harmonics) and band-limited saw (5) use the one shared 32x32 multiplier.
//   Each sine takes six products, each harmonic one more, and every product
//   passes through a multiply state and an accumulate state.
//   Reset selects the sine, reseeds the noise LFSR and drops o_valid and busy.
module multi_waveform_shaper_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mws_pkg::PHASE_BITS-1:0]      i_phase,
    input  logic                                i_cfg_we,
    input  logic [3:0]                          i_cfg_data,
    output logic                                o_valid,
    output logic signed [mws_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                o_clipped
);

    localparam int PB = mws_pkg::PHASE_BITS;
    localparam int VW = mws_pkg::V_W;
    localparam int MW = mws_pkg::M_W;

    localparam logic signed [VW-1:0] V_ONE   = VW'(64'sd1 <<< 30);
    localparam logic [PB-1:0]        HALF    = PB'(64'd1 << (PB - 1));
    localparam logic [PB-1:0]        QUART   = PB'(64'd1 << (PB - 2));
    localparam logic [PB-1:0]        EIGHTH  = PB'(64'd1 << (PB - 3));
    localparam logic signed [VW-1:0] RND     = VW'(64'sd1 <<< (mws_pkg::OUT_SHIFT - 1));
    localparam logic signed [VW-1:0] S_MAX   = VW'((64'sd1 <<< mws_pkg::FRAC_BITS) - 1);
    localparam logic signed [VW-1:0] S_MIN   = -VW'(64'sd1 <<< mws_pkg::FRAC_BITS);

    mws_pkg::t_state r_state, n_state;
    mws_pkg::t_wave  r_wave;

    logic [31:0]           r_lfsr;
    logic [PB-1:0]         r_phase;
    logic [PB-1:0]         r_hphase;
    logic [2:0]            r_k;
    logic [2:0]            r_step;
    logic [30:0]           r_y;
    logic [30:0]           r_y2;
    logic                  r_neg;
    logic signed [MW-1:0]  r_acc;
    logic signed [MW-1:0]  r_sin;
    logic signed [MW-1:0]  r_mul;
    logic signed [VW-1:0]  r_v;
    logic                  r_valid;
    logic signed [mws_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                  r_clipped;

    logic                  use_seq;
    logic                  last_k;
    logic [PB-1:0]         h_inc;

    // shared multiplier: Q30 product, magnitude rounded half up
    logic signed [MW-1:0]  mul_a, mul_b;
    logic [MW-1:0]         mag_a, mag_b;
    logic [2*MW-1:0]       prod;
    logic [MW-1:0]         prod_r;
    logic signed [MW-1:0]  mul_q;

    always_comb begin
        mag_a  = mul_a[MW-1] ? MW'(-mul_a) : MW'(mul_a);
        mag_b  = mul_b[MW-1] ? MW'(-mul_b) : MW'(mul_b);
        prod   = (2*MW)'(mag_a) * (2*MW)'(mag_b) + (2*MW)'(64'd1 << 29);
        prod_r = prod[MW+29:30];
        mul_q  = (mul_a[MW-1] ^ mul_b[MW-1]) ? -$signed(prod_r) : $signed(prod_r);
    end

    assign use_seq = (r_wave == mws_pkg::WAVE_SINE) || (r_wave == mws_pkg::WAVE_BL_SQUARE)
                  || (r_wave == mws_pkg::WAVE_BL_SAW) || (r_wave == mws_pkg::WAVE_RECT_SINE);
    assign last_k  = (r_wave == mws_pkg::WAVE_BL_SQUARE) ? (r_k == mws_pkg::SQ_LAST_K)
                                                         : (r_k == mws_pkg::SAW_LAST_K);
    assign h_inc   = (r_wave == mws_pkg::WAVE_BL_SQUARE) ? (r_phase << 1) : r_phase;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mws_pkg::ST_IDLE: begin
                if (start) n_state = use_seq ? mws_pkg::ST_SETUP : mws_pkg::ST_DIRECT;
            end
            mws_pkg::ST_DIRECT: n_state = mws_pkg::ST_FINAL;
            mws_pkg::ST_SETUP:  n_state = mws_pkg::ST_MUL;
            mws_pkg::ST_MUL:    n_state = mws_pkg::ST_POST;
            mws_pkg::ST_POST: begin
                if (r_step == mws_pkg::STEP_SIN) begin
                    n_state = (r_wave == mws_pkg::WAVE_SINE) ? mws_pkg::ST_FINAL
                                                              : mws_pkg::ST_MUL;
                end else if (r_step == mws_pkg::STEP_POST) begin
                    if (r_wave == mws_pkg::WAVE_RECT_SINE || last_k) begin
                        n_state = mws_pkg::ST_FINAL;
                    end else begin
                        n_state = mws_pkg::ST_SETUP;
                    end
                end else begin
                    n_state = mws_pkg::ST_MUL;
                end
            end
            mws_pkg::ST_FINAL:  n_state = mws_pkg::ST_IDLE;
            default:            n_state = mws_pkg::ST_IDLE;
        endcase
    end

    // outputs and operand select
    always_comb begin
        busy  = (r_state != mws_pkg::ST_IDLE);
        mul_a = r_acc;
        mul_b = $signed({1'b0, r_y2});
        unique case (r_step)
            mws_pkg::STEP_SQR: begin
                mul_a = $signed({1'b0, r_y});
                mul_b = $signed({1'b0, r_y});
            end
            mws_pkg::STEP_C9: mul_a = mws_pkg::SIN_C9;
            mws_pkg::STEP_SIN: mul_b = $signed({1'b0, r_y});
            mws_pkg::STEP_POST: begin
                if (r_wave == mws_pkg::WAVE_RECT_SINE) begin
                    mul_a = r_sin - mws_pkg::RECT_DC;
                    mul_b = mws_pkg::RECT_GAIN;
                end else begin
                    mul_a = r_sin;
                    mul_b = mws_pkg::bl_weight(r_wave == mws_pkg::WAVE_BL_SQUARE, r_k);
                end
            end
            default: ;
        endcase
    end

    // direct shapes and noise
    logic [31:0]          lfsr_nx;
    logic signed [VW-1:0] four_t;
    logic signed [VW-1:0] tmp;
    logic signed [VW-1:0] v_dir;
    logic signed [31:0]   nz;

    always_comb begin
        lfsr_nx = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? mws_pkg::LFSR_TAPS : 32'd0);
        nz      = $signed({~lfsr_nx[31], lfsr_nx[30:0]});
        four_t  = $signed(VW'(r_phase)) <<< (32 - PB);
        tmp     = '0;
        unique case (r_wave)
            mws_pkg::WAVE_SAW:      v_dir = (four_t >>> 1) - V_ONE;
            mws_pkg::WAVE_INV_SAW:  v_dir = V_ONE - (four_t >>> 1);
            mws_pkg::WAVE_SQUARE:   v_dir = (r_phase < HALF) ? -V_ONE : V_ONE;
            mws_pkg::WAVE_TRIANGLE: begin
                tmp   = four_t - (V_ONE <<< 1);
                v_dir = (tmp[VW-1] ? -tmp : tmp) - V_ONE;
            end
            mws_pkg::WAVE_PULSE25:  v_dir = (r_phase < QUART) ? V_ONE : -V_ONE;
            mws_pkg::WAVE_PULSE12:  v_dir = (r_phase < EIGHTH) ? V_ONE : -V_ONE;
            mws_pkg::WAVE_NOISE:    v_dir = VW'(nz >>> 1);
            mws_pkg::WAVE_TRAPEZOID: begin
                tmp = (r_phase < HALF) ? (four_t - V_ONE) : (3 * V_ONE - four_t);
                tmp = tmp <<< 1;
                if (tmp > V_ONE) begin
                    v_dir = V_ONE;
                end else if (tmp < -V_ONE) begin
                    v_dir = -V_ONE;
                end else begin
                    v_dir = tmp;
                end
            end
            mws_pkg::WAVE_STEP_SAW: begin
                tmp   = $signed(VW'(r_phase[PB-1:PB-4])) - VW'(8);
                v_dir = (tmp <<< 27) + (VW'(1) <<< 26);
            end
            default: v_dir = '0;
        endcase
    end

    // clamp of the quarter-wave polynomial
    logic signed [MW-1:0] sin_mag;
    always_comb begin
        if (r_mul[MW-1]) begin
            sin_mag = '0;
        end else if (r_mul > mws_pkg::Q30_ONE) begin
            sin_mag = mws_pkg::Q30_ONE;
        end else begin
            sin_mag = r_mul;
        end
    end

    // output rounding and saturation
    logic signed [VW-1:0] v_out;
    always_comb begin
        v_out = (r_v + RND) >>> mws_pkg::OUT_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mws_pkg::ST_IDLE;
            r_wave  <= mws_pkg::WAVE_SINE;
            r_lfsr  <= mws_pkg::LFSR_SEED;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == mws_pkg::ST_FINAL);
            if (i_cfg_we && i_cfg_data <= mws_pkg::WAVE_LAST) begin
                r_wave <= mws_pkg::t_wave'(i_cfg_data);
            end
            if (r_state == mws_pkg::ST_DIRECT && r_wave == mws_pkg::WAVE_NOISE) begin
                r_lfsr <= lfsr_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mws_pkg::ST_IDLE: begin
                r_phase  <= i_phase;
                r_hphase <= i_phase;
                r_k      <= '0;
                r_v      <= '0;
            end
            mws_pkg::ST_DIRECT: r_v <= v_dir;
            mws_pkg::ST_SETUP: begin
                r_step <= mws_pkg::STEP_SQR;
                r_neg  <= r_hphase[PB-1];
                if (r_hphase[PB-2]) begin
                    r_y <= 31'(64'd1 << 30) - 31'({r_hphase[PB-3:0], (32 - PB)'(0)});
                end else begin
                    r_y <= 31'({r_hphase[PB-3:0], (32 - PB)'(0)});
                end
            end
            mws_pkg::ST_MUL: r_mul <= mul_q;
            mws_pkg::ST_POST: begin
                r_step <= r_step + 3'd1;
                if (r_step == mws_pkg::STEP_SQR) begin
                    r_y2 <= r_mul[30:0];
                end else if (r_step == mws_pkg::STEP_SIN) begin
                    if (r_wave == mws_pkg::WAVE_RECT_SINE) begin
                        r_sin <= sin_mag;
                    end else begin
                        r_sin <= r_neg ? -sin_mag : sin_mag;
                    end
                    if (r_wave == mws_pkg::WAVE_SINE) begin
                        r_v <= r_neg ? VW'(sin_mag) : -VW'(sin_mag);
                    end
                end else if (r_step == mws_pkg::STEP_POST) begin
                    if (r_wave == mws_pkg::WAVE_RECT_SINE) begin
                        r_v <= VW'(r_mul);
                    end else begin
                        r_v      <= r_v - VW'(r_mul);
                        r_k      <= r_k + 3'd1;
                        r_hphase <= r_hphase + h_inc;
                    end
                end else begin
                    r_acc <= mws_pkg::sin_coef(r_step) + r_mul;
                end
            end
            mws_pkg::ST_FINAL: begin
                if (v_out > S_MAX) begin
                    r_sample  <= mws_pkg::SAMPLE_BITS'(S_MAX);
                    r_clipped <= 1'b1;
                end else if (v_out < S_MIN) begin
                    r_sample  <= mws_pkg::SAMPLE_BITS'(S_MIN);
                    r_clipped <= 1'b1;
                end else begin
                    r_sample  <= mws_pkg::SAMPLE_BITS'(v_out);
                    r_clipped <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid   = r_valid;
    assign o_sample  = r_sample;
    assign o_clipped = r_clipped;

endmodule
